### rtl/ila_pkg.sv
// package for the implicit list heap allocator: widths, codes, states and handshake structs
package ila_pkg;

    localparam int REQ_W          = 16;
    localparam int OFF_W          = 15;
    localparam int DIV_W          = REQ_W + 1;
    localparam int HEAP_BYTES_DEF = 32768;
    localparam int TAG_BYTES_DEF  = 8;

    localparam logic OP_ALLOC  = 1'b0;
    localparam logic OP_FREE   = 1'b1;
    localparam logic TAG_FREE  = 1'b0;
    localparam logic TAG_USED  = 1'b1;

    typedef enum logic [3:0] {
        S_INIT_H,
        S_INIT_T,
        S_IDLE,
        S_DIV,
        S_RD,
        S_CHK,
        S_RD_N,
        S_CHK_N,
        S_RD_P,
        S_CHK_P,
        S_W0,
        S_W1,
        S_W2,
        S_W3,
        S_RESP
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic             rem_zero;
    } t_div_rsp;

endpackage

### rtl/ila_ram.sv
// generic single write port ram with registered read
module ila_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/ila_div.sv
// divide by the tag size through a reciprocal multiply, result registered in the cycle after start
module ila_div #(
    parameter int TAG_BYTES = ila_pkg::TAG_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ila_pkg::t_div_req i_req,
    output ila_pkg::t_div_rsp o_rsp
);

    localparam int DW = ila_pkg::DIV_W;
    localparam int LW = $clog2(TAG_BYTES);
    localparam int SH = DW + LW;
    localparam int MW = DW + 1;
    localparam int PW = DW + MW;
    // ceil(2^SH / TAG_BYTES): the floor is exact for every dividend below 2^DW
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + 64'(TAG_BYTES) - 64'd1) / 64'(TAG_BYTES));

    logic          r_done, n_done;
    logic [DW-1:0] r_q, n_q;
    logic [DW-1:0] r_num, n_num;
    logic [PW-1:0] w_prod;
    logic [DW-1:0] w_quot;
    logic [DW-1:0] w_back;

    assign w_prod = PW'(i_req.dividend) * PW'(RECIP);
    assign w_quot = DW'(w_prod >> SH);
    // quotient times tag size equals the dividend only when nothing is left over
    assign w_back = r_q * DW'(TAG_BYTES);

    always_comb begin
        n_done = i_req.start;
        n_q    = r_q;
        n_num  = r_num;
        if (i_req.start) begin
            n_q   = w_quot;
            n_num = i_req.dividend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= n_done;
        end
        r_q   <= n_q;
        r_num <= n_num;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quot     = r_q;
    assign o_rsp.rem_zero = (w_back == r_num);

endmodule

### rtl/implicit_list_heap_allocator.sv
// top level: boundary tag heap allocator, first fit walk over a tag memory
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+--------------------------------------
//  request  | in        | i_in_valid / o_in_ready     | i_operation, i_request_size,
//           |           |                             | i_payload_offset
//  result   | out       | o_out_valid / i_out_ready   | o_result_offset, o_success
//
//  allocate: accept, divide, read and check per block walked, header and trailer writes on a
//  grant (and the remainder's on a split), result; free: accept, divide, walk to the target,
//  next and previous neighbour reads where present, header and trailer writes, result; the
//  walk is bound by the single tag memory read port; after reset the initial free block is
//  written, with no transfer taken meanwhile; a finished result sits in the output register;
//  the next request is taken while it waits, its result held in S_RESP till the register frees
module implicit_list_heap_allocator #(
    parameter int HEAP_BYTES = ila_pkg::HEAP_BYTES_DEF,
    parameter int TAG_BYTES  = ila_pkg::TAG_BYTES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_operation,
    input  logic [ila_pkg::REQ_W-1:0] i_request_size,
    input  logic [ila_pkg::OFF_W-1:0] i_payload_offset,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [ila_pkg::OFF_W-1:0] o_result_offset,
    output logic                      o_success
);

    // positions and sizes are kept in tag units; a tag word is {size, in-use}
    localparam int DEPTH  = HEAP_BYTES / TAG_BYTES;
    localparam int IW     = $clog2(DEPTH);
    localparam int SW     = $clog2(DEPTH + 1);
    localparam int WW     = SW + 1;
    localparam int NEED_W = ila_pkg::DIV_W + 1;
    localparam int CW     = ((SW > NEED_W) ? SW : NEED_W) + 1;
    localparam int BW     = $clog2(DEPTH * TAG_BYTES + 1);
    localparam int XW     = (BW > ila_pkg::OFF_W) ? BW : ila_pkg::OFF_W;

    ila_pkg::t_state r_state, n_state;

    // request and walk registers
    logic                        r_op, n_op;
    logic [ila_pkg::OFF_W-1:0]   r_poff, n_poff;
    logic [NEED_W-1:0]           r_need, n_need;
    logic [ila_pkg::DIV_W-1:0]   r_tidx, n_tidx;
    logic                        r_exact, n_exact;
    logic [SW-1:0]               r_pos, n_pos;
    logic [SW-1:0]               r_sz1, n_sz1;
    logic [SW-1:0]               r_sz2, n_sz2;
    logic                        r_used, n_used;
    logic                        r_split, n_split;
    logic                        r_succ, n_succ;
    logic [ila_pkg::OFF_W-1:0]   r_res_off, n_res_off;

    // output register
    logic                        r_out_valid, n_out_valid;
    logic [ila_pkg::OFF_W-1:0]   r_out_off, n_out_off;
    logic                        r_out_succ, n_out_succ;

    // memory and divider ports
    logic                        ram_we;
    logic [IW-1:0]               ram_waddr;
    logic [WW-1:0]               ram_wdata;
    logic [IW-1:0]               ram_raddr;
    logic [WW-1:0]               ram_rdata;
    ila_pkg::t_div_req           div_req;
    ila_pkg::t_div_rsp           div_rsp;

    // decode of the tag just read
    logic [SW-1:0]               w_tsize;
    logic                        w_tused;
    logic [SW-1:0]               w_room;
    logic [SW-1:0]               w_walk;
    logic [SW-1:0]               w_nend;
    logic [SW-1:0]               w_room_n;
    logic [SW-1:0]               w_end1;
    logic [SW-1:0]               w_hdr2;
    logic [SW-1:0]               w_end2;
    logic [SW-1:0]               w_prev;
    logic                        w_blk_ok;
    logic                        w_more;
    logic                        w_fit;
    logic                        w_split;
    logic                        w_hit;
    logic                        w_past;
    logic                        w_pos_nz;
    logic                        w_next_merge;
    logic                        w_prev_merge;
    logic                        w_bad_free;
    logic                        w_accept;
    logic                        w_out_free;
    logic [XW-1:0]               w_pay_byte;

    ila_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_tags (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ila_div #(
        .TAG_BYTES (TAG_BYTES)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign w_tsize  = ram_rdata[WW-1:1];
    assign w_tused  = ram_rdata[0];
    assign w_room   = SW'(DEPTH) - r_pos;
    assign w_walk   = r_pos + w_tsize;
    assign w_nend   = r_pos + r_sz1;
    assign w_room_n = SW'(DEPTH) - w_nend;
    assign w_end1   = r_pos + r_sz1 - SW'(1);
    assign w_hdr2   = r_pos + r_sz1;
    assign w_end2   = r_pos + r_sz1 + r_sz2 - SW'(1);
    assign w_prev   = r_pos - SW'(1);

    // block sane: non-zero size that stays inside the heap
    assign w_blk_ok = (w_tsize != '0) && (w_tsize <= w_room);
    assign w_more   = w_walk < SW'(DEPTH);
    assign w_fit    = !w_tused && (CW'(w_tsize) >= CW'(r_need));
    // split only when at least three tags would be left over
    assign w_split  = CW'(w_tsize) >= (CW'(r_need) + CW'(3));
    assign w_hit    = (CW'(r_pos) == CW'(r_tidx)) && r_exact;
    assign w_past   = CW'(r_pos) > CW'(r_tidx);
    assign w_pos_nz = (r_pos != '0);
    assign w_next_merge = !w_tused && (w_tsize != '0) && (w_tsize <= w_room_n);
    assign w_prev_merge = !w_tused && (w_tsize != '0) && (w_tsize <= r_pos);
    assign w_bad_free   = ila_pkg::DIV_W'(r_poff) < ila_pkg::DIV_W'(TAG_BYTES);

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_pay_byte = (XW'(r_pos) + XW'(1)) * XW'(TAG_BYTES);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ila_pkg::S_INIT_H: n_state = ila_pkg::S_INIT_T;
            ila_pkg::S_INIT_T: n_state = ila_pkg::S_IDLE;
            ila_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = ila_pkg::S_DIV;
                end
            end
            ila_pkg::S_DIV: begin
                if (div_rsp.done) begin
                    if (r_op == ila_pkg::OP_FREE && w_bad_free) begin
                        n_state = ila_pkg::S_RESP;
                    end else begin
                        n_state = ila_pkg::S_RD;
                    end
                end
            end
            ila_pkg::S_RD: n_state = ila_pkg::S_CHK;
            ila_pkg::S_CHK: begin
                if (!w_blk_ok) begin
                    n_state = ila_pkg::S_RESP;
                end else if (r_op == ila_pkg::OP_ALLOC) begin
                    if (w_fit) begin
                        n_state = ila_pkg::S_W0;
                    end else if (w_more) begin
                        n_state = ila_pkg::S_RD;
                    end else begin
                        n_state = ila_pkg::S_RESP;
                    end
                end else if (w_hit) begin
                    if (!w_tused) begin
                        n_state = ila_pkg::S_RESP;
                    end else if (w_more) begin
                        n_state = ila_pkg::S_RD_N;
                    end else if (w_pos_nz) begin
                        n_state = ila_pkg::S_RD_P;
                    end else begin
                        n_state = ila_pkg::S_W0;
                    end
                end else if (w_past || !w_more) begin
                    n_state = ila_pkg::S_RESP;
                end else begin
                    n_state = ila_pkg::S_RD;
                end
            end
            ila_pkg::S_RD_N: n_state = ila_pkg::S_CHK_N;
            ila_pkg::S_CHK_N: begin
                n_state = w_pos_nz ? ila_pkg::S_RD_P : ila_pkg::S_W0;
            end
            ila_pkg::S_RD_P:  n_state = ila_pkg::S_CHK_P;
            ila_pkg::S_CHK_P: n_state = ila_pkg::S_W0;
            ila_pkg::S_W0:    n_state = ila_pkg::S_W1;
            ila_pkg::S_W1: begin
                n_state = r_split ? ila_pkg::S_W2 : ila_pkg::S_RESP;
            end
            ila_pkg::S_W2: n_state = ila_pkg::S_W3;
            ila_pkg::S_W3: n_state = ila_pkg::S_RESP;
            ila_pkg::S_RESP: begin
                if (w_out_free) begin
                    n_state = ila_pkg::S_IDLE;
                end
            end
            default: n_state = ila_pkg::S_INIT_H;
        endcase
    end

    // memory, divider and handshake controls
    always_comb begin
        ram_we           = 1'b0;
        ram_waddr        = r_pos[IW-1:0];
        ram_wdata        = {r_sz1, r_used};
        ram_raddr        = r_pos[IW-1:0];
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        o_in_ready       = 1'b0;
        case (r_state)
            ila_pkg::S_INIT_H: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = {SW'(DEPTH), ila_pkg::TAG_FREE};
            end
            ila_pkg::S_INIT_T: begin
                ram_we    = 1'b1;
                ram_waddr = IW'(DEPTH - 1);
                ram_wdata = {SW'(DEPTH), ila_pkg::TAG_FREE};
            end
            ila_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                div_req.start = w_accept;
                // allocate rounds up; free takes the header position of the payload
                if (i_operation == ila_pkg::OP_ALLOC) begin
                    div_req.dividend = ila_pkg::DIV_W'(i_request_size)
                                     + ila_pkg::DIV_W'(TAG_BYTES - 1);
                end else begin
                    div_req.dividend = ila_pkg::DIV_W'(i_payload_offset)
                                     - ila_pkg::DIV_W'(TAG_BYTES);
                end
            end
            ila_pkg::S_RD_N: ram_raddr = w_nend[IW-1:0];
            ila_pkg::S_RD_P: ram_raddr = w_prev[IW-1:0];
            ila_pkg::S_W0: begin
                ram_we = 1'b1;
            end
            ila_pkg::S_W1: begin
                ram_we    = 1'b1;
                ram_waddr = w_end1[IW-1:0];
            end
            ila_pkg::S_W2: begin
                ram_we    = 1'b1;
                ram_waddr = w_hdr2[IW-1:0];
                ram_wdata = {r_sz2, ila_pkg::TAG_FREE};
            end
            ila_pkg::S_W3: begin
                ram_we    = 1'b1;
                ram_waddr = w_end2[IW-1:0];
                ram_wdata = {r_sz2, ila_pkg::TAG_FREE};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // datapath registers
    always_comb begin
        n_op      = r_op;
        n_poff    = r_poff;
        n_need    = r_need;
        n_tidx    = r_tidx;
        n_exact   = r_exact;
        n_pos     = r_pos;
        n_sz1     = r_sz1;
        n_sz2     = r_sz2;
        n_used    = r_used;
        n_split   = r_split;
        n_succ    = r_succ;
        n_res_off = r_res_off;
        case (r_state)
            ila_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_op      = i_operation;
                    n_poff    = i_payload_offset;
                    n_succ    = 1'b0;
                    n_res_off = '0;
                    n_split   = 1'b0;
                end
            end
            ila_pkg::S_DIV: begin
                n_pos   = '0;
                n_need  = NEED_W'(div_rsp.quot) + NEED_W'(2);
                n_tidx  = div_rsp.quot;
                n_exact = div_rsp.rem_zero;
            end
            ila_pkg::S_CHK: begin
                if (r_op == ila_pkg::OP_ALLOC) begin
                    if (w_blk_ok && w_fit) begin
                        n_used    = ila_pkg::TAG_USED;
                        n_succ    = 1'b1;
                        n_res_off = w_pay_byte[ila_pkg::OFF_W-1:0];
                        if (w_split) begin
                            n_split = 1'b1;
                            n_sz1   = SW'(r_need);
                            n_sz2   = SW'(CW'(w_tsize) - CW'(r_need));
                        end else begin
                            n_sz1 = w_tsize;
                        end
                    end else begin
                        n_pos = w_walk;
                    end
                end else if (w_blk_ok && w_hit) begin
                    // found block: success whatever the neighbours hold
                    n_sz1  = w_tsize;
                    n_used = ila_pkg::TAG_FREE;
                    n_succ = w_tused;
                end else begin
                    n_pos = w_walk;
                end
            end
            ila_pkg::S_CHK_N: begin
                if (w_next_merge) begin
                    n_sz1 = r_sz1 + w_tsize;
                end
            end
            ila_pkg::S_CHK_P: begin
                if (w_prev_merge) begin
                    n_pos = r_pos - w_tsize;
                    n_sz1 = r_sz1 + w_tsize;
                end
            end
            default: begin
                n_op = r_op;
            end
        endcase
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_off   = r_out_off;
        n_out_succ  = r_out_succ;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (r_state == ila_pkg::S_RESP && w_out_free) begin
            n_out_valid = 1'b1;
            n_out_off   = r_res_off;
            n_out_succ  = r_succ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ila_pkg::S_INIT_H;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_op       <= n_op;
        r_poff     <= n_poff;
        r_need     <= n_need;
        r_tidx     <= n_tidx;
        r_exact    <= n_exact;
        r_pos      <= n_pos;
        r_sz1      <= n_sz1;
        r_sz2      <= n_sz2;
        r_used     <= n_used;
        r_split    <= n_split;
        r_succ     <= n_succ;
        r_res_off  <= n_res_off;
        r_out_off  <= n_out_off;
        r_out_succ <= n_out_succ;
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_offset = r_out_off;
    assign o_success       = r_out_succ;

endmodule

### tb/heap_reply_checker.sv
// checker: boundary tag heap predictor and in-order comparison of result transfers
module heap_reply_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic                      i_operation,
    input  logic [ila_pkg::REQ_W-1:0] i_request_size,
    input  logic [ila_pkg::OFF_W-1:0] i_payload_offset,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [ila_pkg::OFF_W-1:0] i_result_offset,
    input  logic                      i_success,
    output int unsigned               o_mismatches,
    output int unsigned               o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          OFF_W        = ila_pkg::OFF_W;
    localparam int unsigned HEAP_BYTES   = ila_pkg::HEAP_BYTES_DEF;
    localparam int unsigned TAG_BYTES    = ila_pkg::TAG_BYTES_DEF;
    localparam int unsigned TAG_WORDS    = HEAP_BYTES / TAG_BYTES;
    localparam int unsigned USABLE_BYTES = TAG_WORDS * TAG_BYTES;

    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic             success;
    } t_heap_reply;

    logic [15:0] tag_words [TAG_WORDS];
    t_heap_reply expected_replies [$];
    int unsigned mismatch_total = 0;

    function automatic logic [15:0] read_tag(input int unsigned pos);
        int unsigned idx;
        idx = pos / TAG_BYTES;
        return (idx < TAG_WORDS) ? tag_words[idx] : 16'd0;
    endfunction

    task automatic write_tag(input int unsigned pos, input logic [15:0] value);
        int unsigned idx;
        idx = pos / TAG_BYTES;
        if (idx < TAG_WORDS) begin
            tag_words[idx] = value;
        end
    endtask

    // header and trailer carry the same word
    task automatic set_block(input int unsigned pos, input int unsigned size, input logic used);
        logic [15:0] word;
        word = size[15:0] | {15'd0, used};
        write_tag(pos, word);
        if (size >= TAG_BYTES) begin
            write_tag(pos + size - TAG_BYTES, word);
        end
    endtask

    function automatic bit block_fits(input int unsigned pos, input int unsigned size);
        return size != 0 && size <= USABLE_BYTES - pos;
    endfunction

    task automatic clear_heap();
        for (int unsigned i = 0; i < TAG_WORDS; i++) begin
            tag_words[i] = 16'd0;
        end
        set_block(0, USABLE_BYTES, ila_pkg::TAG_FREE);
    endtask

    // first fit walk, split when three tags or more would be left over
    task automatic grant_request(input int unsigned req, output t_heap_reply reply);
        int unsigned need;
        int unsigned pos;
        int unsigned size;
        int unsigned payload;
        logic [15:0] word;
        bit          done;
        need  = ((req + TAG_BYTES - 1) / TAG_BYTES) * TAG_BYTES + 2 * TAG_BYTES;
        pos   = 0;
        done  = 0;
        reply = '0;
        while (!done && pos < USABLE_BYTES) begin
            word = read_tag(pos);
            size = {16'd0, word[15:1], 1'b0};
            if (!block_fits(pos, size)) begin
                done = 1;
            end else if (word[0] == ila_pkg::TAG_FREE && size >= need) begin
                if (size >= need + 3 * TAG_BYTES) begin
                    set_block(pos, need, ila_pkg::TAG_USED);
                    set_block(pos + need, size - need, ila_pkg::TAG_FREE);
                end else begin
                    set_block(pos, size, ila_pkg::TAG_USED);
                end
                payload       = pos + TAG_BYTES;
                reply.offset  = payload[OFF_W-1:0];
                reply.success = 1'b1;
                done          = 1;
            end else begin
                pos += size;
            end
        end
    endtask

    // free only an in-use block start, then merge with next and previous
    task automatic release_block(input int unsigned poff, output t_heap_reply reply);
        int unsigned target;
        int unsigned pos;
        int unsigned size;
        int unsigned nb_size;
        logic [15:0] word;
        bit          found;
        bit          done;
        reply = '0;
        found = 0;
        done  = 0;
        pos   = 0;
        size  = 0;
        if (poff >= TAG_BYTES) begin
            target = poff - TAG_BYTES;
            while (!done && pos < USABLE_BYTES) begin
                word = read_tag(pos);
                size = {16'd0, word[15:1], 1'b0};
                if (!block_fits(pos, size)) begin
                    done = 1;
                end else if (pos == target) begin
                    found = word[0];
                    done  = 1;
                end else if (pos > target) begin
                    done = 1;
                end else begin
                    pos += size;
                end
            end
        end
        if (found) begin
            set_block(pos, size, ila_pkg::TAG_FREE);
            if (pos + size < USABLE_BYTES) begin
                word    = read_tag(pos + size);
                nb_size = {16'd0, word[15:1], 1'b0};
                if (word[0] == ila_pkg::TAG_FREE && block_fits(pos + size, nb_size)) begin
                    size += nb_size;
                    set_block(pos, size, ila_pkg::TAG_FREE);
                end
            end
            if (pos != 0) begin
                word    = read_tag(pos - TAG_BYTES);
                nb_size = {16'd0, word[15:1], 1'b0};
                if (word[0] == ila_pkg::TAG_FREE && nb_size != 0 && nb_size <= pos) begin
                    set_block(pos - nb_size, nb_size + size, ila_pkg::TAG_FREE);
                end
            end
            reply.success = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_heap_reply got;
        t_heap_reply want;
        t_heap_reply reply;
        if (!i_rst_n) begin
            clear_heap();
            expected_replies.delete();
        end else begin
            // results first: a request taken at this edge cannot answer at the same edge
            if (i_out_valid && i_out_ready) begin
                got.offset  = i_result_offset;
                got.success = i_success;
                if (expected_replies.size() == 0) begin
                    mismatch_total++;
                    $display("%0t: result transfer with none expected: offset %0d success %0b",
                             $time, got.offset, got.success);
                end else begin
                    want = expected_replies.pop_front();
                    if (got.offset !== want.offset) begin
                        mismatch_total++;
                        $display("%0t: result_offset expected %0d actual %0d",
                                 $time, want.offset, got.offset);
                    end
                    if (got.success !== want.success) begin
                        mismatch_total++;
                        $display("%0t: success expected %0b actual %0b",
                                 $time, want.success, got.success);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_operation == ila_pkg::OP_ALLOC) begin
                    grant_request(i_request_size, reply);
                end else begin
                    release_block(i_payload_offset, reply);
                end
                expected_replies.push_back(reply);
            end
        end
        o_outstanding <= expected_replies.size();
        o_mismatches  <= mismatch_total;
    end

endmodule

### tb/tb_implicit_list_heap_allocator.sv
// testbench top: stimulus, handshake pacing and verdict for the heap allocator
module tb_implicit_list_heap_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          REQ_W        = ila_pkg::REQ_W;
    localparam int          OFF_W        = ila_pkg::OFF_W;
    localparam int unsigned TAG_BYTES    = ila_pkg::TAG_BYTES_DEF;
    // slowest item here walks ~80 blocks plus stalls; this is several times over
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned HOLD_CYCLES  = 500;
    localparam int unsigned PHASE_ITEMS  = 175;
    localparam int unsigned POOL_CAP     = 40;
    localparam int unsigned FREED_KEEP   = 32;
    localparam int unsigned DRAIN_CYCLES = 64;

    logic             clk            = 1'b0;
    logic             rst_n          = 1'b0;
    logic             in_valid       = 1'b0;
    logic             in_ready;
    logic             operation      = ila_pkg::OP_ALLOC;
    logic [REQ_W-1:0] request_size   = '0;
    logic [OFF_W-1:0] payload_offset = '0;
    logic             out_valid;
    logic             out_ready      = 1'b0;
    logic [OFF_W-1:0] result_offset;
    logic             success;

    int unsigned mismatches;
    int unsigned outstanding;

    // pacing knobs, set per phase by the stimulus process
    int unsigned sender_idle_pct   = 31;
    int unsigned receiver_idle_pct = 69;
    int unsigned hold_seq          = 0;
    int unsigned hold_seen         = 0;
    int unsigned hold_left         = 0;
    int unsigned cycle_count       = 0;

    // payload offsets handed out by the block, used to build sensible frees
    logic [OFF_W-1:0] live_payloads  [$];
    logic [OFF_W-1:0] freed_payloads [$];

    int unsigned allocs_sent = 0;
    int unsigned frees_sent  = 0;
    int unsigned grants_seen = 0;
    int unsigned frees_done  = 0;

    implicit_list_heap_allocator uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_operation      (operation),
        .i_request_size   (request_size),
        .i_payload_offset (payload_offset),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_result_offset  (result_offset),
        .o_success        (success)
    );

    heap_reply_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_operation      (operation),
        .i_request_size   (request_size),
        .i_payload_offset (payload_offset),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_result_offset  (result_offset),
        .i_success        (success),
        .o_mismatches     (mismatches),
        .o_outstanding    (outstanding)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // receiver: random back-pressure, or a long hold-off when the stimulus asks for one
    always @(posedge clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // successful results with a non-zero offset are grants, the rest are frees done
    always @(posedge clk) begin
        if (out_valid && out_ready && success) begin
            if (result_offset != 0) begin
                live_payloads.push_back(result_offset);
                grants_seen++;
            end else begin
                frees_done++;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // one request transfer; valid stays up from the previous item unless an idle gap comes first
    task automatic send_item(input logic op, input logic [REQ_W-1:0] req,
                             input logic [OFF_W-1:0] poff);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        operation      <= op;
        request_size   <= req;
        payload_offset <= poff;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        if (op == ila_pkg::OP_ALLOC) begin
            allocs_sent++;
        end else begin
            frees_sent++;
        end
    endtask

    // sender goes quiet until the checker holds no expectation
    task automatic wait_drained();
        in_valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (outstanding != 0);
    endtask

    task automatic alloc(input int unsigned req);
        send_item(ila_pkg::OP_ALLOC, REQ_W'(req), '0);
    endtask

    task automatic release_at(input int unsigned poff);
        send_item(ila_pkg::OP_FREE, '0, OFF_W'(poff));
    endtask

    // mostly well-formed alloc/free traffic, with some bad frees and oversized requests
    task automatic send_random_item();
        int unsigned      roll;
        int unsigned      idx;
        int unsigned      size_roll;
        logic [REQ_W-1:0] req;
        logic [OFF_W-1:0] poff;
        roll = $urandom_range(99);
        req  = REQ_W'($urandom_range(16'hFFFF));
        poff = OFF_W'($urandom_range(15'h7FFF));
        if (live_payloads.size() != 0 && (live_payloads.size() >= POOL_CAP || roll < 38)) begin
            idx  = $urandom_range(live_payloads.size() - 1);
            poff = live_payloads[idx];
            live_payloads.delete(idx);
            freed_payloads.push_back(poff);
            if (freed_payloads.size() > FREED_KEEP) begin
                void'(freed_payloads.pop_front());
            end
            send_item(ila_pkg::OP_FREE, req, poff);
        end else if (roll < 50) begin
            case ($urandom_range(3))
                0: begin
                    // double free of something already given back
                    if (freed_payloads.size() != 0) begin
                        poff = freed_payloads[$urandom_range(freed_payloads.size() - 1)];
                    end
                    send_item(ila_pkg::OP_FREE, req, poff);
                end
                1: begin
                    // offset one or two tags past a live payload, usually inside that live block
                    if (live_payloads.size() != 0) begin
                        poff = live_payloads[$urandom_range(live_payloads.size() - 1)]
                               + OFF_W'(TAG_BYTES * $urandom_range(1, 2));
                    end
                    send_item(ila_pkg::OP_FREE, req, poff);
                end
                2: begin
                    send_item(ila_pkg::OP_FREE, req, poff);
                end
                default: begin
                    // larger than the whole heap, or close to it
                    send_item(ila_pkg::OP_ALLOC, REQ_W'($urandom_range(32700, 16'hFFFF)), poff);
                end
            endcase
        end else begin
            size_roll = $urandom_range(99);
            if (size_roll < 70) begin
                req = REQ_W'($urandom_range(64));
            end else if (size_roll < 95) begin
                req = REQ_W'($urandom_range(65, 2048));
            end else begin
                req = REQ_W'($urandom_range(2049, 16'hFFFF));
            end
            send_item(ila_pkg::OP_ALLOC, req, poff);
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed part on a fresh heap: blocks land at 0 (16 B), 16 (24 B), 40 (24 B), 64 (32 B)
        alloc(0);              // empty payload, two tags only
        alloc(1);
        alloc(8);
        alloc(9);
        alloc(16'hFFFF);       // far too large
        alloc(32752);          // whole heap, no longer free
        release_at(0);         // below one tag
        release_at(7);
        release_at(56);        // inside the block at 40
        release_at(48);        // both neighbours in use
        release_at(48);        // double free
        release_at(24);        // merges with the free block after it
        release_at(72);        // merges both ways
        release_at(8);         // first block, heap whole again
        alloc(32752);          // exact fit of the whole heap, no split
        release_at(8);
        alloc(32728);          // leaves exactly three tags, split
        alloc(8);              // exact fit of the last block
        release_at(32752);     // last block, previous in use
        release_at(8);
        alloc(32736);          // two tags left over, no split
        release_at(8);
        release_at(16'h7FFF);  // top offset, no such block
        wait_drained();
        live_payloads.delete();

        // random part in three pacing phases
        for (int unsigned phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct   = 31;
                    receiver_idle_pct = 69;
                end
                1: begin
                    sender_idle_pct   = 69;
                    receiver_idle_pct = 31;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
                if (phase == 0 && k == 60) begin
                    // long receiver stall while requests keep coming: input must back up
                    hold_seq <= hold_seq + 1;
                end
                send_random_item();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("run covered %0d allocates (%0d granted) and %0d frees (%0d done)",
                 allocs_sent, grants_seen, frees_sent, frees_done);
        $display("pacing: 31/69, 69/31 and 0/0 idle percent, one %0d-cycle result hold-off",
                 HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
